FILE: design/rope_pkg.sv
`timescale 1ns / 1ps

package rope_pkg;

   // field widths of the request and the response
   localparam int POS_W      = 11;
   localparam int PAIR_W     = 6;
   localparam int VALUE_W    = 16;
   localparam int FRAC_BITS  = 14;
   localparam int PAIRS_W    = 7;
   localparam int PROD_W     = 2 * VALUE_W;
   localparam int ADDR_W     = POS_W + PAIR_W;
   localparam int TABLE_DEPTH = 1 << ADDR_W;

   // pair count limits
   localparam logic [PAIRS_W-1:0] MAX_PAIRS   = 7'd64;
   localparam logic [PAIRS_W-1:0] PAIRS_RESET = 7'd64;

   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_ROTATE = 1'b1
   } opcode_type;

   // one rotate request after the table read
   typedef struct packed {
      logic signed [VALUE_W-1:0] x;
      logic signed [VALUE_W-1:0] y;
      logic signed [VALUE_W-1:0] c;
      logic signed [VALUE_W-1:0] s;
      logic                      tail;
   } rope_stage_type;

endpackage

FILE: design/rope_ifs.sv
`timescale 1ns / 1ps

interface rope_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    opcode;
   logic        [rope_pkg::POS_W-1:0]       position;
   logic        [rope_pkg::PAIR_W-1:0]      pair_index;
   logic signed [rope_pkg::VALUE_W-1:0]     first_value;
   logic signed [rope_pkg::VALUE_W-1:0]     second_value;

   modport source (
      output valid, opcode, position, pair_index, first_value, second_value,
      input  ready
   );
   modport sink (
      input  valid, opcode, position, pair_index, first_value, second_value,
      output ready
   );
endinterface

interface rope_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [rope_pkg::VALUE_W-1:0]     first_result;
   logic signed [rope_pkg::VALUE_W-1:0]     second_result;
   logic                                    saturated;

   modport source (
      output valid, first_result, second_result, saturated,
      input  ready
   );
   modport sink (
      input  valid, first_result, second_result, saturated,
      output ready
   );
endinterface

FILE: design/rope_rotate.sv
`timescale 1ns / 1ps

module rope_rotate (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  rope_pkg::rope_stage_type in_data,
   rope_rsp_if.source               rsp_bus
);

   localparam int SUM_W = rope_pkg::PROD_W + 1;
   localparam int RES_W = SUM_W - rope_pkg::FRAC_BITS;

   logic                                     s2_valid_ff;
   logic signed [rope_pkg::PROD_W-1:0]       xc_ff, ys_ff, yc_ff, xs_ff;
   logic signed [rope_pkg::VALUE_W-1:0]      x_ff, y_ff;
   logic                                     tail_ff;

   logic                                     out_valid_ff;
   logic signed [rope_pkg::VALUE_W-1:0]      first_ff, first_in;
   logic signed [rope_pkg::VALUE_W-1:0]      second_ff, second_in;
   logic                                     sat_ff, sat_in;

   logic                                     out_en, s2_en;
   logic signed [SUM_W-1:0]                  sum_x, sum_y;
   logic                                     sat_x, sat_y;
   logic signed [rope_pkg::VALUE_W-1:0]      rx, ry;

   // round half up, shift down and clip to the value range
   function automatic logic [rope_pkg::VALUE_W:0] round_sat(input logic signed [SUM_W-1:0] acc);
      logic signed [SUM_W-1:0]             rnd;
      logic signed [RES_W-1:0]             shf;
      logic                                fits;
      logic signed [rope_pkg::VALUE_W-1:0] val;
      rnd  = acc + (SUM_W'(1) <<< (rope_pkg::FRAC_BITS - 1));
      shf  = rnd[SUM_W-1:rope_pkg::FRAC_BITS];
      fits = (shf[RES_W-1:rope_pkg::VALUE_W-1] == '0) ||
             (shf[RES_W-1:rope_pkg::VALUE_W-1] == '1);
      if (fits) begin
         val = shf[rope_pkg::VALUE_W-1:0];
      end else if (shf[RES_W-1]) begin
         val = {1'b1, {(rope_pkg::VALUE_W-1){1'b0}}};
      end else begin
         val = {1'b0, {(rope_pkg::VALUE_W-1){1'b1}}};
      end
      return {!fits, val};
   endfunction

   // advance a stage when the one after it is free
   assign out_en   = !out_valid_ff || rsp_bus.ready;
   assign s2_en    = !s2_valid_ff || out_en;
   assign in_ready = s2_en;

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= in_valid;
      end
      if (s2_en && in_valid) begin
         xc_ff   <= in_data.x * in_data.c;
         ys_ff   <= in_data.y * in_data.s;
         yc_ff   <= in_data.y * in_data.c;
         xs_ff   <= in_data.x * in_data.s;
         x_ff    <= in_data.x;
         y_ff    <= in_data.y;
         tail_ff <= in_data.tail;
      end
   end

   // add, round and saturate
   always_comb begin
      sum_x = SUM_W'(xc_ff) - SUM_W'(ys_ff);
      sum_y = SUM_W'(yc_ff) + SUM_W'(xs_ff);
      {sat_x, rx} = round_sat(sum_x);
      {sat_y, ry} = round_sat(sum_y);
      if (tail_ff) begin
         first_in  = x_ff;
         second_in = y_ff;
         sat_in    = 1'b0;
      end else begin
         first_in  = rx;
         second_in = ry;
         sat_in    = sat_x || sat_y;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s2_valid_ff;
      end
      if (out_en && s2_valid_ff) begin
         first_ff  <= first_in;
         second_ff <= second_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.first_result  = first_ff;
   assign rsp_bus.second_result = second_ff;
   assign rsp_bus.saturated     = sat_ff;

endmodule

FILE: design/rotary_position_embedding.sv
`timescale 1ns / 1ps
// A rotate request has its table read at the accepting edge, then passes the multiply register,
// then round and saturate into the output register; a response stall can hold it on the way.
// Throughput: one request per cycle while responses are not stalled, set by the single table port.
// Table writes give no response.
// Reset clears the pipeline valid bits and sets rotary_pairs to 64; the
// angle table is not cleared and holds no valid bits.

module rotary_position_embedding (
   input  logic                          clock,
   input  logic                          reset,
   rope_req_if.sink                      req_bus,
   rope_rsp_if.source                    rsp_bus,
   input  logic                          csr_we,
   input  logic [rope_pkg::PAIRS_W-1:0]  csr_wdata
);

   logic [2*rope_pkg::VALUE_W-1:0] angle_mem [rope_pkg::TABLE_DEPTH];

   logic [rope_pkg::PAIRS_W-1:0]        rotary_pairs_ff;
   logic [rope_pkg::PAIRS_W-1:0]        active_pairs;
   logic [rope_pkg::ADDR_W-1:0]         addr;
   logic                                accept;
   logic                                is_rotate;
   logic                                s1_en;
   logic                                rot_ready;

   logic                                s1_valid_ff;
   logic [2*rope_pkg::VALUE_W-1:0]      rd_ff;
   logic signed [rope_pkg::VALUE_W-1:0] x_ff, y_ff;
   logic                                tail_ff, tail_in;
   rope_pkg::rope_stage_type            s1_data;

   // hold the pair count register
   always_ff @(posedge clock) begin
      if (reset) begin
         rotary_pairs_ff <= rope_pkg::PAIRS_RESET;
      end else if (csr_we) begin
         rotary_pairs_ff <= csr_wdata;
      end
   end

   assign active_pairs = (rotary_pairs_ff > rope_pkg::MAX_PAIRS) ? rope_pkg::MAX_PAIRS
                                                                  : rotary_pairs_ff;
   assign tail_in   = {1'b0, req_bus.pair_index} >= active_pairs;
   assign addr      = {req_bus.position, req_bus.pair_index};
   assign is_rotate = rope_pkg::opcode_type'(req_bus.opcode) == rope_pkg::OP_ROTATE;
   assign s1_en     = !s1_valid_ff || rot_ready;
   assign accept    = req_bus.valid && s1_en;
   assign req_bus.ready = s1_en;

   // table: write or read at the accepted request's entry
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!is_rotate) begin
            angle_mem[addr] <= {req_bus.first_value, req_bus.second_value};
         end
         rd_ff <= angle_mem[addr];
      end
   end

   // read stage: hold the values alongside the table data
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= accept && is_rotate;
      end
      if (accept) begin
         x_ff    <= req_bus.first_value;
         y_ff    <= req_bus.second_value;
         tail_ff <= tail_in;
      end
   end

   always_comb begin
      s1_data.x    = x_ff;
      s1_data.y    = y_ff;
      s1_data.c    = rd_ff[2*rope_pkg::VALUE_W-1:rope_pkg::VALUE_W];
      s1_data.s    = rd_ff[rope_pkg::VALUE_W-1:0];
      s1_data.tail = tail_ff;
   end

   rope_rotate u_rotate (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s1_valid_ff),
      .in_ready (rot_ready),
      .in_data  (s1_data),
      .rsp_bus  (rsp_bus)
   );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import rope_pkg::*;

   typedef struct {
      logic signed [VALUE_W-1:0] first_result;
      logic signed [VALUE_W-1:0] second_result;
      logic                      saturated;
   } rotation_result;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_e;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [PAIRS_W-1:0] csr_wdata;

   rope_req_if req ();
   rope_rsp_if rsp ();

   rotary_position_embedding u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // shadow of the angle table and the pair count register
   logic signed [VALUE_W-1:0] angle_cos [int];
   logic signed [VALUE_W-1:0] angle_sin [int];
   int                        written_keys [$];
   logic [PAIRS_W-1:0]        pair_count;

   rotation_result pending_rotations [$];
   int             error_count;
   int             burst_left;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop for a hung run
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int table_key(input logic [POS_W-1:0] pos, input logic [PAIR_W-1:0] pair);
      return int'({pos, pair});
   endfunction

   // round half up, shift out the fraction, clip to the value range
   function automatic logic clip_to_value(input longint acc,
                                          output logic signed [VALUE_W-1:0] v);
      longint r;
      longint hi;
      longint lo;
      r  = (acc + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
      hi = (64'sd1 << (VALUE_W - 1)) - 1;
      lo = -hi - 1;
      if (r > hi) begin
         v = hi[VALUE_W-1:0];
         return 1'b1;
      end
      if (r < lo) begin
         v = lo[VALUE_W-1:0];
         return 1'b1;
      end
      v = r[VALUE_W-1:0];
      return 1'b0;
   endfunction

   function automatic rotation_result predict_rotation(input logic [POS_W-1:0] pos,
                                                       input logic [PAIR_W-1:0] pair,
                                                       input logic signed [VALUE_W-1:0] x,
                                                       input logic signed [VALUE_W-1:0] y);
      rotation_result     r;
      logic [PAIRS_W-1:0] active;
      longint             c;
      longint             s;
      longint             xv;
      longint             yv;
      logic               sat_x;
      logic               sat_y;
      int                 key;
      active = (pair_count > MAX_PAIRS) ? MAX_PAIRS : pair_count;
      // tail pairs copy straight through
      if ({1'b0, pair} >= active) begin
         r.first_result  = x;
         r.second_result = y;
         r.saturated     = 1'b0;
         return r;
      end
      key   = table_key(pos, pair);
      c     = angle_cos[key];
      s     = angle_sin[key];
      xv    = x;
      yv    = y;
      sat_x = clip_to_value(xv * c - yv * s, r.first_result);
      sat_y = clip_to_value(yv * c + xv * s, r.second_result);
      r.saturated = sat_x | sat_y;
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(VALUE_W-1){1'b0}}};
         1: return {1'b0, {(VALUE_W-1){1'b1}}};
         2: return '0;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // plausible unit-circle values half the time, otherwise any sample
   function automatic logic signed [VALUE_W-1:0] random_angle();
      if ($urandom_range(0, 1) == 0)
         return VALUE_W'($urandom_range(0, 32768) - 16384);
      return random_sample();
   endfunction

   // drive one request, wait for acceptance, then update the shadow state
   task automatic send_request(input opcode_type op,
                               input logic [POS_W-1:0] pos,
                               input logic [PAIR_W-1:0] pair,
                               input logic signed [VALUE_W-1:0] a,
                               input logic signed [VALUE_W-1:0] b);
      int key;
      req.valid        <= 1'b1;
      req.opcode       <= op;
      req.position     <= pos;
      req.pair_index   <= pair;
      req.first_value  <= a;
      req.second_value <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      key = table_key(pos, pair);
      if (op == OP_WRITE) begin
         if (!angle_cos.exists(key))
            written_keys.push_back(key);
         angle_cos[key] = a;
         angle_sin[key] = b;
      end else begin
         pending_rotations.push_back(predict_rotation(pos, pair, a, b));
      end
      // end of burst: drop valid for a random gap
      burst_left--;
      if (burst_left <= 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 15 : 3)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 12);
      end
   endtask

   // hold requests until every response is back and the pipe is empty
   task automatic wait_until_idle();
      req.valid <= 1'b0;
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_pair_count(input logic [PAIRS_W-1:0] value);
      wait_until_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we     <= 1'b0;
      pair_count = value;
   endtask

   // identity, quarter turn, overwrite and full-scale entries
   task automatic test_angle_extremes();
      send_request(OP_WRITE,  11'd0,    6'd0,  16'sd16384,  16'sd0);
      send_request(OP_ROTATE, 11'd0,    6'd0,  16'sd32767, -16'sd32768);
      send_request(OP_WRITE,  11'd2047, 6'd63, -16'sd32768, -16'sd32768);
      send_request(OP_ROTATE, 11'd2047, 6'd63, -16'sd32768, 16'sd32767);
      send_request(OP_ROTATE, 11'd2047, 6'd63, 16'sd32767,  16'sd32767);
      send_request(OP_WRITE,  11'd1024, 6'd32, 16'sd11585,  16'sd11585);
      send_request(OP_ROTATE, 11'd1024, 6'd32, 16'sd32767,  16'sd32767);
      send_request(OP_WRITE,  11'd1,    6'd1,  16'sd0,      16'sd16384);
      send_request(OP_ROTATE, 11'd1,    6'd1,  16'sd100,   -16'sd200);
      send_request(OP_WRITE,  11'd0,    6'd0,  -16'sd16384, 16'sd0);
      send_request(OP_ROTATE, 11'd0,    6'd0,  -16'sd32768, 16'sd0);
      send_request(OP_WRITE,  11'd1365, 6'd42, 16'sh5555,   -16'sd10922);
      send_request(OP_ROTATE, 11'd1365, 6'd42, 16'sd0,      16'sd0);
   endtask

   // values on both sides of the rounding point
   task automatic test_rounding();
      send_request(OP_WRITE,  11'd5,   6'd5,  16'sd1,      16'sd0);
      send_request(OP_ROTATE, 11'd5,   6'd5,  16'sd8192,  -16'sd8192);
      send_request(OP_ROTATE, 11'd5,   6'd5,  16'sd8191,  -16'sd8193);
      send_request(OP_WRITE,  11'd682, 6'd21, -16'sd1,     16'sd1);
      send_request(OP_ROTATE, 11'd682, 6'd21, -16'sd24575, 16'sd8192);
   endtask

   // pair count at zero, one, below and above the table width
   task automatic test_tail_copy();
      set_pair_count(7'd0);
      send_request(OP_ROTATE, 11'd0,    6'd0,  16'sd1234,   -16'sd4321);
      send_request(OP_ROTATE, 11'd2047, 6'd63, -16'sd32768, 16'sd32767);
      set_pair_count(7'd63);
      send_request(OP_ROTATE, 11'd2047, 6'd63, 16'sd777,    -16'sd1);
      send_request(OP_ROTATE, 11'd1365, 6'd42, 16'sd20000,  -16'sd20000);
      set_pair_count(7'd127);
      send_request(OP_ROTATE, 11'd2047, 6'd63, 16'sd300,    16'sd400);
      set_pair_count(7'd1);
      send_request(OP_ROTATE, 11'd0,    6'd0,  16'sd5000,   -16'sd6000);
      send_request(OP_ROTATE, 11'd1,    6'd1,  -16'sd32768, 16'sd32767);
   endtask

   // random mix of table writes and rotates of written entries
   task automatic test_random_stream(input int count);
      int               n;
      int               sel;
      int               key;
      logic [POS_W-1:0]  pos;
      logic [PAIR_W-1:0] pair;
      for (n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (written_keys.size() == 0 || sel < 25) begin
            pos  = POS_W'($urandom_range(0, 2047));
            pair = PAIR_W'($urandom_range(0, 63));
            send_request(OP_WRITE, pos, pair, random_angle(), random_angle());
            // read right behind the write now and then
            if ($urandom_range(0, 3) == 0)
               send_request(OP_ROTATE, pos, pair, random_sample(), random_sample());
         end else begin
            key  = written_keys[$urandom_range(0, written_keys.size() - 1)];
            pos  = key[ADDR_W-1:PAIR_W];
            pair = key[PAIR_W-1:0];
            if (sel < 32)
               send_request(OP_WRITE, pos, pair, random_angle(), random_angle());
            else
               send_request(OP_ROTATE, pos, pair, random_sample(), random_sample());
         end
      end
   endtask

   task automatic report_mismatch(input string field, input int want, input int got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
   endtask

   // compare each response with the oldest prediction
   always @(posedge clock) begin : check_rotations
      rotation_result want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_rotations.size() == 0) begin
            report_mismatch("unexpected response first_result", 0, rsp.first_result);
         end else begin
            want = pending_rotations.pop_front();
            if (rsp.first_result !== want.first_result)
               report_mismatch("first_result", want.first_result, rsp.first_result);
            if (rsp.second_result !== want.second_result)
               report_mismatch("second_result", want.second_result, rsp.second_result);
            if (rsp.saturated !== want.saturated)
               report_mismatch("saturated", want.saturated, rsp.saturated);
         end
      end
   end

   // response back-pressure: switch between stall patterns at random
   initial begin : response_stalls
      stall_mode_e mode;
      int          span;
      int          i;
      rsp.ready <= 1'b1;
      forever begin
         mode = stall_mode_e'($urandom_range(0, 3));
         span = $urandom_range(40, 200);
         for (i = 0; i < span; i++) begin
            @(posedge clock);
            case (mode)
               STALL_NONE:     rsp.ready <= 1'b1;
               STALL_RANDOM:   rsp.ready <= 1'($urandom_range(0, 1));
               STALL_PERIODIC: rsp.ready <= (i % 3) != 2;
               default:        rsp.ready <= (i % 32) >= 20;
            endcase
         end
      end
   end

   initial begin
      error_count = 0;
      burst_left  = 1;
      pair_count  = PAIRS_RESET;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_wdata        <= '0;
      req.valid        <= 1'b0;
      req.opcode       <= OP_WRITE;
      req.position     <= '0;
      req.pair_index   <= '0;
      req.first_value  <= '0;
      req.second_value <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_angle_extremes();
      test_rounding();
      test_tail_copy();

      set_pair_count(7'd64);
      test_random_stream(240);
      set_pair_count(PAIRS_W'($urandom_range(1, 63)));
      test_random_stream(200);
      set_pair_count(7'd0);
      test_random_stream(90);
      set_pair_count(7'd127);
      test_random_stream(90);
      set_pair_count(PAIRS_W'($urandom_range(1, 63)));
      test_random_stream(220);

      wait_until_idle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: files.f
design/rope_pkg.sv
design/rope_ifs.sv
design/rope_rotate.sv
design/rotary_position_embedding.sv
tb/tb.sv
